[hw/rtl/mirrored_phase_pattern_sequencer_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef MIRRORED_PHASE_PATTERN_SEQUENCER_TOP_ASSERT_SVH
`define MIRRORED_PHASE_PATTERN_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define MPPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define MPPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mpps_pkg.sv]
package mpps_pkg;

    // Store geometry
    localparam int MAX_PHASES_DEFAULT = 16;
    localparam int WORDS_PER_PHASE    = 9;
    localparam int WORD_W             = 32;
    localparam int LEVELS_PER_SIDE    = 4;
    localparam int NUM_LEVELS         = 2 * LEVELS_PER_SIDE;
    localparam int SLOT_W             = 4;
    localparam int ADDR_W             = 8;

    // Slot layout inside one row
    localparam int SLOT_DURATION = 0;
    localparam int SLOT_LEFT     = 1;
    localparam int SLOT_RIGHT    = SLOT_LEFT + LEVELS_PER_SIDE;

    // Configuration
    localparam int STARTUP_W   = 4;
    localparam int CYCLIC_W    = 5;
    localparam int PHASE_OUT_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_STARTUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLIC  = 1'b1;

    localparam logic [STARTUP_W-1:0] STARTUP_RESET = 4'd0;
    localparam logic [CYCLIC_W-1:0]  CYCLIC_RESET  = 5'd2;
    localparam logic [CYCLIC_W-1:0]  CYCLIC_MIN    = 5'd2;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Divide by nine through a reciprocal, exact for any 8-bit index
    localparam int RECIP_W     = 6;
    localparam int RECIP_MUL   = 57;
    localparam int RECIP_SHIFT = 9;

    typedef logic [WORDS_PER_PHASE*WORD_W-1:0] row_t;

    typedef struct packed {
        logic [ADDR_W-1:0] row_idx;
        logic [SLOT_W-1:0] slot;
    } word_loc_t;

    // Pending tick result handed from the phase unit to the output stage
    typedef struct packed {
        logic                   swap;
        logic [PHASE_OUT_W-1:0] phase;
    } tick_info_t;

    // Split a flat word index into row and slot
    function automatic word_loc_t split_index(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W+RECIP_W-1:0] prod;
        logic [ADDR_W-1:0]         quo;
        logic [ADDR_W-1:0]         rem;
        word_loc_t                 loc;
        prod = (ADDR_W+RECIP_W)'(idx) * (ADDR_W+RECIP_W)'(RECIP_MUL);
        quo  = ADDR_W'(prod >> RECIP_SHIFT);
        rem  = idx - ADDR_W'(quo * WORDS_PER_PHASE);
        loc.row_idx = quo;
        loc.slot    = SLOT_W'(rem);
        return loc;
    endfunction

    // Pick one word out of a row
    function automatic logic [WORD_W-1:0] row_word(input row_t row, input int slot);
        return row[slot*WORD_W +: WORD_W];
    endfunction

endpackage

[hw/rtl/mpps_if.sv]
interface mpps_item_if
    import mpps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    logic [WORD_W-1:0] sim_time;

    modport source (output valid, op, word_index, word_value, sim_time, input ready);
    modport sink   (input valid, op, word_index, word_value, sim_time, output ready);
endinterface

interface mpps_result_if
    import mpps_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [PHASE_OUT_W-1:0]   phase;
    logic signed [WORD_W-1:0] left_temporalis;
    logic signed [WORD_W-1:0] left_masseter;
    logic signed [WORD_W-1:0] left_medial;
    logic signed [WORD_W-1:0] left_lateral;
    logic signed [WORD_W-1:0] right_temporalis;
    logic signed [WORD_W-1:0] right_masseter;
    logic signed [WORD_W-1:0] right_medial;
    logic signed [WORD_W-1:0] right_lateral;

    modport source (output valid, phase, left_temporalis, left_masseter, left_medial,
                    left_lateral, right_temporalis, right_masseter, right_medial,
                    right_lateral, input ready);
    modport sink   (input valid, phase, left_temporalis, left_masseter, left_medial,
                    left_lateral, right_temporalis, right_masseter, right_medial,
                    right_lateral, output ready);
endinterface

[hw/rtl/mpps_store.sv]
module mpps_store
    import mpps_pkg::*;
#(
    parameter int MAX_PHASES = MAX_PHASES_DEFAULT
)(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_PHASES)-1:0] wr_row,
    input  logic [SLOT_W-1:0]             wr_slot,
    input  logic [WORD_W-1:0]             wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_PHASES)-1:0] rd_row,
    output row_t                          rd_data
);

    row_t mem [MAX_PHASES];
    row_t rd_data_reg;

    // Write one word of a row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row][wr_slot*WORD_W +: WORD_W] <= wr_data;
        end
    end

    // Read a whole row into a registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mpps_phase.sv]
module mpps_phase
    import mpps_pkg::*;
#(
    parameter int MAX_PHASES = MAX_PHASES_DEFAULT
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [ADDR_W-1:0]             in_word_index,
    input  logic [WORD_W-1:0]             in_word_value,
    input  logic [WORD_W-1:0]             in_sim_time,
    output logic                          wr_en,
    output logic [$clog2(MAX_PHASES)-1:0] wr_row,
    output logic [SLOT_W-1:0]             wr_slot,
    output logic [WORD_W-1:0]             wr_data,
    output logic                          rd_en,
    output logic [$clog2(MAX_PHASES)-1:0] rd_row,
    input  logic [WORD_W-1:0]             rd_duration,
    input  logic                          out_free,
    output logic                          t2_valid,
    output tick_info_t                    t2_info
);

    localparam int PH_W        = $clog2(MAX_PHASES);
    localparam int CW          = ((PH_W > CYCLIC_W) ? PH_W : CYCLIC_W) + 2;
    localparam int STORE_WORDS = MAX_PHASES * WORDS_PER_PHASE;
    localparam int SW_W        = $clog2(STORE_WORDS + 1);
    localparam int IW          = (SW_W > ADDR_W) ? SW_W : ADDR_W;

    // Returns {swap, row} for a phase
    function automatic logic [PH_W:0] row_sel(input logic [PH_W-1:0] p,
                                              input logic [CW-1:0] base,
                                              input logic [CW-1:0] hv);
        logic [CW-1:0] pw;
        logic [PH_W:0] res;
        pw = CW'(p);
        if (pw >= base && pw >= hv)
        begin
            res = {1'b1, PH_W'(pw - hv)};
        end
        else
        begin
            res = {1'b0, p};
        end
        return res;
    endfunction

    logic [STARTUP_W-1:0] startup_reg;
    logic [CYCLIC_W-1:0]  cyclic_reg;

    logic [PH_W-1:0]   phase_reg,    phase_next;
    logic [WORD_W-1:0] tip_reg,      tip_next;
    logic [WORD_W-1:0] prev_reg,     prev_next;
    logic              t1_valid_reg, t1_valid_next;
    logic [WORD_W-1:0] t1_time_reg;
    logic              t2_valid_reg, t2_valid_next;
    tick_info_t        t2_info_reg;

    logic [CYCLIC_W-1:0] cyc_eff;
    logic [CW-1:0]       half_w;
    logic [CW-1:0]       sum_w;
    logic [CW-1:0]       total_w;
    logic [CW-1:0]       wrap_w;
    logic [CW-1:0]       base_w;

    logic [WORD_W-1:0] elapsed;
    logic [WORD_W:0]   sum33;
    logic [WORD_W-1:0] tip_sat;
    logic              advance;
    logic [CW-1:0]     p_inc;
    logic [CW-1:0]     p_new_w;
    logic [PH_W-1:0]   p_new;
    logic [PH_W:0]     cur_sel;
    logic [PH_W:0]     new_sel;

    logic      accept;
    logic      tick_acc;
    word_loc_t loc;
    logic      idx_ok;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_reg <= STARTUP_RESET;
            cyclic_reg  <= CYCLIC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STARTUP: startup_reg <= cfg_wdata[STARTUP_W-1:0];
                REG_CYCLIC:  cyclic_reg  <= cfg_wdata[CYCLIC_W-1:0];
                default:     ;
            endcase
        end
    end

    // Derive phase limits from the configuration
    always_comb
    begin
        cyc_eff = (cyclic_reg < CYCLIC_MIN) ? CYCLIC_MIN : cyclic_reg;
        half_w  = CW'(cyc_eff >> 1);
        sum_w   = CW'(startup_reg) + CW'(cyc_eff);
        total_w = (sum_w > CW'(MAX_PHASES)) ? CW'(MAX_PHASES) : sum_w;
        wrap_w  = (CW'(startup_reg) < total_w) ? CW'(startup_reg) : total_w - CW'(1);
        base_w  = CW'(startup_reg) + half_w;
    end

    // Handshake: one tick in flight, hold off while a finished tick is stuck
    assign in_ready = !t1_valid_reg && !(t2_valid_reg && !out_free);
    assign accept   = in_valid && in_ready;
    assign tick_acc = accept && (in_op == OP_TICK);

    // Load path straight into the store
    assign loc     = split_index(in_word_index);
    assign idx_ok  = IW'(in_word_index) < IW'(STORE_WORDS);
    assign wr_en   = accept && (in_op == OP_LOAD) && idx_ok;
    assign wr_row  = PH_W'(loc.row_idx);
    assign wr_slot = loc.slot;
    assign wr_data = in_word_value;

    // Time accumulation and phase advance
    always_comb
    begin
        elapsed = t1_time_reg - prev_reg;
        sum33   = {1'b0, tip_reg} + {1'b0, elapsed};
        tip_sat = sum33[WORD_W] ? {WORD_W{1'b1}} : sum33[WORD_W-1:0];
        advance = tip_sat > rd_duration;
        p_inc   = CW'(phase_reg) + (advance ? CW'(1) : CW'(0));
        p_new_w = (p_inc >= total_w) ? wrap_w : p_inc;
        p_new   = PH_W'(p_new_w);
    end

    assign cur_sel = row_sel(phase_reg, base_w, half_w);
    assign new_sel = row_sel(p_new, base_w, half_w);

    // Row read: current phase at accept, new phase on the following cycle
    assign rd_en  = tick_acc || t1_valid_reg;
    assign rd_row = t1_valid_reg ? new_sel[PH_W-1:0] : cur_sel[PH_W-1:0];

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        tip_next      = tip_reg;
        prev_next     = prev_reg;
        t1_valid_next = tick_acc;
        t2_valid_next = t2_valid_reg && !out_free;
        if (t1_valid_reg)
        begin
            phase_next    = p_new;
            tip_next      = advance ? '0 : tip_sat;
            prev_next     = t1_time_reg;
            t2_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            tip_reg      <= '0;
            prev_reg     <= '0;
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tip_reg      <= tip_next;
            prev_reg     <= prev_next;
            t1_valid_reg <= t1_valid_next;
            t2_valid_reg <= t2_valid_next;
        end
    end

    // Payload: tick time and the pending result's phase and mirror flag
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            t1_time_reg <= in_sim_time;
        end
        if (t1_valid_reg)
        begin
            t2_info_reg.swap  <= new_sel[PH_W];
            t2_info_reg.phase <= PHASE_OUT_W'(p_new);
        end
    end

    assign t2_valid = t2_valid_reg;
    assign t2_info  = t2_info_reg;

endmodule

[hw/rtl/mpps_out.sv]
module mpps_out
    import mpps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     t2_valid,
    input  tick_info_t               t2_info,
    input  row_t                     rd_data,
    input  logic                     out_ready,
    output logic                     out_free,
    output logic                     out_valid,
    output logic [PHASE_OUT_W-1:0]   out_phase,
    output logic signed [WORD_W-1:0] out_level [NUM_LEVELS]
);

    logic                     valid_reg, valid_next;
    logic [PHASE_OUT_W-1:0]   phase_reg;
    logic signed [WORD_W-1:0] level_reg [NUM_LEVELS];
    logic                     load;

    assign out_free = !valid_reg || out_ready;
    assign load     = t2_valid && out_free;

    // Drop the word once taken, refill from the pending tick
    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture levels, swapping sides on mirrored phases
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            phase_reg <= t2_info.phase;
            for (int k = 0; k < LEVELS_PER_SIDE; k++)
            begin
                level_reg[k] <= t2_info.swap ? row_word(rd_data, SLOT_RIGHT + k)
                                             : row_word(rd_data, SLOT_LEFT + k);
                level_reg[LEVELS_PER_SIDE + k] <= t2_info.swap ? row_word(rd_data, SLOT_LEFT + k)
                                                               : row_word(rd_data, SLOT_RIGHT + k);
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_phase = phase_reg;
    assign out_level = level_reg;

endmodule

[hw/rtl/mirrored_phase_pattern_sequencer_top.sv]
// Channel   Dir  Payload                                      Accepted when
// item      in   op, word_index, word_value, sim_time         valid & ready
// result    out  phase, four left and four right levels       valid & ready
// cfg       in   cfg_index, cfg_wdata                         cfg_we
//
// A tick blocks the input while its phase updates: the store's single read port serves the
// current phase's duration, then the new phase's row. Its result passes the t1, t2 and output
// registers. Loads write the store on acceptance, one per cycle except right after a tick or
// when the input stalls. Reset zeroes phase, times and the startup count (cyclic count two);
// the store has no reset. A stalled result holds the output; the input then stalls once a
// second finished tick waits behind it.
module mirrored_phase_pattern_sequencer_top
    import mpps_pkg::*;
#(
    parameter int MAX_PHASES = MAX_PHASES_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    mpps_item_if.sink             item,
    mpps_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PH_W = $clog2(MAX_PHASES);

    logic                     wr_en;
    logic [PH_W-1:0]          wr_row;
    logic [SLOT_W-1:0]        wr_slot;
    logic [WORD_W-1:0]        wr_data;
    logic                     rd_en;
    logic [PH_W-1:0]          rd_row;
    row_t                     rd_data;
    logic                     out_free;
    logic                     t2_valid;
    tick_info_t               t2_info;
    logic signed [WORD_W-1:0] level [NUM_LEVELS];

    mpps_phase #(
        .MAX_PHASES (MAX_PHASES)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (item.valid),
        .in_ready      (item.ready),
        .in_op         (item.op),
        .in_word_index (item.word_index),
        .in_word_value (item.word_value),
        .in_sim_time   (item.sim_time),
        .wr_en         (wr_en),
        .wr_row        (wr_row),
        .wr_slot       (wr_slot),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_row        (rd_row),
        .rd_duration   (row_word(rd_data, SLOT_DURATION)),
        .out_free      (out_free),
        .t2_valid      (t2_valid),
        .t2_info       (t2_info)
    );

    mpps_store #(
        .MAX_PHASES (MAX_PHASES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_slot (wr_slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    mpps_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .t2_valid  (t2_valid),
        .t2_info   (t2_info),
        .rd_data   (rd_data),
        .out_ready (result.ready),
        .out_free  (out_free),
        .out_valid (result.valid),
        .out_phase (result.phase),
        .out_level (level)
    );

    assign result.left_temporalis  = level[0];
    assign result.left_masseter    = level[1];
    assign result.left_medial      = level[2];
    assign result.left_lateral     = level[3];
    assign result.right_temporalis = level[4];
    assign result.right_masseter   = level[5];
    assign result.right_medial     = level[6];
    assign result.right_lateral    = level[7];

endmodule

[hw/rtl/mpps_checker.sv]
`include "mirrored_phase_pattern_sequencer_top_assert.svh"

module mpps_checker
    import mpps_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_op,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [PHASE_OUT_W-1:0]   out_phase,
    input logic signed [WORD_W-1:0] out_lt,
    input logic signed [WORD_W-1:0] out_lm,
    input logic signed [WORD_W-1:0] out_ld,
    input logic signed [WORD_W-1:0] out_ll,
    input logic signed [WORD_W-1:0] out_rt,
    input logic signed [WORD_W-1:0] out_rm,
    input logic signed [WORD_W-1:0] out_rd,
    input logic signed [WORD_W-1:0] out_rl
);

    logic                                  tick_acc;
    logic                                  out_stall;
    logic [PHASE_OUT_W+NUM_LEVELS*WORD_W-1:0] out_word;

    assign tick_acc  = in_valid && in_ready && (in_op == OP_TICK);
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {out_phase, out_lt, out_lm, out_ld, out_ll,
                        out_rt, out_rm, out_rd, out_rl};

    // A stalled result word holds
    `MPPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word), "result word changed while stalled")

    // A tick blocks the input for the cycle that updates the phase
    `MPPS_ASSERT_NXT(a_tick_interlock, clk, rst_n, tick_acc, !in_ready, "input ready right after a tick")

    // A tick into an empty output shows a result once through the phase unit and output register
    `MPPS_ASSERT_IMP(a_tick_latency, clk, rst_n, tick_acc && !out_valid, ##3 out_valid, "tick result missing")

endmodule

bind mirrored_phase_pattern_sequencer_top mpps_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_op     (item.op),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_phase (result.phase),
    .out_lt    (result.left_temporalis),
    .out_lm    (result.left_masseter),
    .out_ld    (result.left_medial),
    .out_ll    (result.left_lateral),
    .out_rt    (result.right_temporalis),
    .out_rm    (result.right_masseter),
    .out_rd    (result.right_medial),
    .out_rl    (result.right_lateral)
);

[test/mirrored_phase_pattern_sequencer_top_tb.sv]
module mirrored_phase_pattern_sequencer_top_tb
    import mpps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_WORDS  = MAX_PHASES_DEFAULT * WORDS_PER_PHASE;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHORT_DUR    = 40;
    localparam int STEP_MAX     = 48;

    // One expected tick result: phase, then left levels 0..3 and right levels 4..7
    typedef struct packed {
        logic [PHASE_OUT_W-1:0]            phase;
        logic [NUM_LEVELS-1:0][WORD_W-1:0] level;
    } phase_levels_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    mpps_item_if   item_ch ();
    mpps_result_if result_ch ();

    mirrored_phase_pattern_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Sequencer shadow state
    logic [WORD_W-1:0]    pattern_mem [STORE_WORDS];
    logic [STARTUP_W-1:0] reg_startup;
    logic [CYCLIC_W-1:0]  reg_cyclic;
    int unsigned          seq_phase;
    logic [WORD_W-1:0]    time_in_phase;
    logic [WORD_W-1:0]    last_time;

    phase_levels_t phase_levels_q [$];
    int            mismatches;
    bit            src_idle_on;
    bit            sink_idle_on;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Row that holds the words of phase p; mirrored phases borrow a row half a cycle back
    function automatic int unsigned source_row(input int unsigned p, output bit mirrored);
        int unsigned start;
        int unsigned half;
        start    = reg_startup;
        half     = ((reg_cyclic < CYCLIC_MIN) ? CYCLIC_MIN : reg_cyclic) / 2;
        mirrored = (p >= start + half) && (p >= half);
        return mirrored ? p - half : p;
    endfunction

    // Advance the phase for one tick and queue the levels it should output
    function automatic void step_sequencer(input logic [WORD_W-1:0] t);
        int unsigned   start;
        int unsigned   cyc;
        int unsigned   total;
        int unsigned   wrap_to;
        int unsigned   row;
        logic [WORD_W:0] sum;
        bit            mirrored;
        phase_levels_t pl;
        start   = reg_startup;
        cyc     = (reg_cyclic < CYCLIC_MIN) ? CYCLIC_MIN : reg_cyclic;
        total   = start + cyc;
        if (total > MAX_PHASES_DEFAULT)
            total = MAX_PHASES_DEFAULT;
        wrap_to = (start < total) ? start : total - 1;

        // Saturating accumulate of the modulo elapsed time
        sum = {1'b0, time_in_phase} + {1'b0, WORD_W'(t - last_time)};
        time_in_phase = sum[WORD_W] ? '1 : sum[WORD_W-1:0];

        row = source_row(seq_phase, mirrored);
        if (time_in_phase > pattern_mem[row * WORDS_PER_PHASE + SLOT_DURATION])
        begin
            time_in_phase = '0;
            seq_phase++;
        end
        if (seq_phase >= total)
            seq_phase = wrap_to;
        last_time = t;

        row = source_row(seq_phase, mirrored);
        pl.phase = PHASE_OUT_W'(seq_phase);
        for (int k = 0; k < LEVELS_PER_SIDE; k++)
        begin
            pl.level[k] = mirrored ? pattern_mem[row * WORDS_PER_PHASE + SLOT_RIGHT + k]
                                   : pattern_mem[row * WORDS_PER_PHASE + SLOT_LEFT + k];
            pl.level[LEVELS_PER_SIDE + k] =
                mirrored ? pattern_mem[row * WORDS_PER_PHASE + SLOT_LEFT + k]
                         : pattern_mem[row * WORDS_PER_PHASE + SLOT_RIGHT + k];
        end
        phase_levels_q.push_back(pl);
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Send one word on the item channel and update the shadow state on acceptance
    task automatic send_word(input logic op, input logic [ADDR_W-1:0] idx,
                             input logic [WORD_W-1:0] value, input logic [WORD_W-1:0] t);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.op         = op;
        item_ch.word_index = idx;
        item_ch.word_value = value;
        item_ch.sim_time   = t;
        item_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (op == OP_TICK)
            step_sequencer(t);
        else if (idx < STORE_WORDS)
            pattern_mem[idx] = value;
    endtask

    task automatic send_load(input logic [ADDR_W-1:0] idx, input logic [WORD_W-1:0] value);
        send_word(OP_LOAD, idx, value, $urandom);
    endtask

    task automatic send_tick(input logic [WORD_W-1:0] t);
        send_word(OP_TICK, ADDR_W'($urandom), $urandom, t);
    endtask

    // Drop valid, wait out every pending result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (phase_levels_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_STARTUP)
            reg_startup = data[STARTUP_W-1:0];
        else
            reg_cyclic = data[CYCLIC_W-1:0];
    endtask

    // Mostly steady time steps and short durations so phases keep moving; some noise
    task automatic random_items(input int count);
        int          slot;
        logic [7:0]  idx;
        logic [31:0] value;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                idx   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(STORE_WORDS, 255))
                                                    : 8'($urandom_range(0, STORE_WORDS - 1));
                slot  = idx % WORDS_PER_PHASE;
                value = $urandom;
                if (idx < STORE_WORDS && slot == SLOT_DURATION && $urandom_range(0, 15) != 0)
                    value = $urandom_range(0, SHORT_DUR);
                send_load(idx, value);
            end
            else if ($urandom_range(0, 7) == 0)
                send_tick($urandom);
            else
                send_tick(last_time + $urandom_range(0, STEP_MAX));
        end
    endtask

    // Fill every store word so no tick ever reads an unwritten entry
    task automatic test_table_preload();
        for (int i = 0; i < STORE_WORDS; i++)
        begin
            if (i % WORDS_PER_PHASE == SLOT_DURATION)
                send_load(8'(i), $urandom_range(0, SHORT_DUR));
            else
                send_load(8'(i), $urandom);
        end
    endtask

    task automatic test_directed_edges();
        int unsigned row;
        bit          mirrored;
        // Extreme levels in row 0, zero duration
        send_load(8'(SLOT_DURATION), 32'd0);
        send_load(8'(SLOT_LEFT), 32'h8000_0000);
        send_load(8'(SLOT_LEFT + 3), 32'h7FFF_FFFF);
        send_load(8'(SLOT_RIGHT), 32'h0000_0000);
        send_load(8'(SLOT_RIGHT + 3), 32'hFFFF_FFFF);
        // Out-of-range loads are dropped
        send_load(8'(STORE_WORDS), $urandom);
        send_load(8'hFF, $urandom);
        // Hold, advance into the mirrored phase, then wrap on time going backwards
        send_tick(32'd0);
        send_tick(32'd1);
        send_tick(32'd0);
        // Saturate time in phase against a maximal duration
        row = source_row(seq_phase, mirrored);
        send_load(8'(row * WORDS_PER_PHASE + SLOT_DURATION), 32'hFFFF_FFFF);
        send_tick(last_time + 32'hF000_0000);
        send_tick(last_time + 32'hF000_0000);
        send_tick(last_time);
        send_load(8'(row * WORDS_PER_PHASE + SLOT_DURATION), 32'd3);
        send_tick(last_time + 32'd1);
        send_tick(32'hFFFF_FFFF);
    endtask

    // Register extremes, odd cyclic counts, counts below the minimum, clamped totals
    task automatic test_register_extremes();
        int unsigned starts [8] = '{0, 15, 0, 15, 3, 0, 1, 7};
        int unsigned cycles [8] = '{2, 16, 16, 2, 5, 0, 1, 9};
        for (int s = 0; s < 8; s++)
        begin
            wait_idle();
            write_reg(REG_STARTUP, CFG_DATA_W'(starts[s]));
            write_reg(REG_CYCLIC, CFG_DATA_W'(cycles[s]));
            random_items(25);
        end
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 10; seg++)
        begin
            wait_idle();
            write_reg(REG_STARTUP, CFG_DATA_W'($urandom_range(0, 15)));
            write_reg(REG_CYCLIC, CFG_DATA_W'($urandom_range(2, 16)));
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            random_items(120);
        end
        // Run the tail back to back on both sides
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        random_items(120);
    endtask

    // Result sink: stall in random bursts while enabled
    initial
    begin
        int stall;
        stall           = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                result_ch.ready = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall           = $urandom_range(0, 14);
                result_ch.ready = 1'b0;
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        phase_levels_t got;
        phase_levels_t want;
        string         names [NUM_LEVELS];
        names = '{"left_temporalis", "left_masseter", "left_medial", "left_lateral",
                  "right_temporalis", "right_masseter", "right_medial", "right_lateral"};
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.phase    = result_ch.phase;
            got.level[0] = result_ch.left_temporalis;
            got.level[1] = result_ch.left_masseter;
            got.level[2] = result_ch.left_medial;
            got.level[3] = result_ch.left_lateral;
            got.level[4] = result_ch.right_temporalis;
            got.level[5] = result_ch.right_masseter;
            got.level[6] = result_ch.right_medial;
            got.level[7] = result_ch.right_lateral;
            if (phase_levels_q.size() == 0)
                report_mismatch("result with nothing pending, phase", WORD_W'(got.phase), '0);
            else
            begin
                want = phase_levels_q.pop_front();
                if (got.phase !== want.phase)
                    report_mismatch("phase", WORD_W'(got.phase), WORD_W'(want.phase));
                for (int k = 0; k < NUM_LEVELS; k++)
                    if (got.level[k] !== want.level[k])
                        report_mismatch(names[k], got.level[k], want.level[k]);
            end
        end
    end

    // Reset, run each test in turn, then report
    initial
    begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_LOAD;
        item_ch.word_index = '0;
        item_ch.word_value = '0;
        item_ch.sim_time   = '0;
        cfg_we             = 1'b0;
        cfg_index          = REG_STARTUP;
        cfg_wdata          = '0;
        reg_startup        = STARTUP_RESET;
        reg_cyclic         = CYCLIC_RESET;
        seq_phase          = 0;
        time_in_phase      = '0;
        last_time          = '0;
        mismatches         = 0;
        src_idle_on        = 1'b1;
        sink_idle_on       = 1'b1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_table_preload();
        test_directed_edges();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
